### rtl/sfr_pkg.sv
package sfr_pkg;

  localparam int KEY_MAX    = 16;
  localparam int REPL_MAX   = 16;
  localparam int COUNT_BITS = 16;

  localparam int LEN_W     = 5;
  localparam int WORD_W    = 64;
  localparam int LIMIT_W   = 16;
  localparam int CFG_IDX_W = 3;

  localparam int FILL_W   = $clog2(KEY_MAX + 1);
  localparam int EMIT_MAX = (KEY_MAX > REPL_MAX) ? KEY_MAX : REPL_MAX;
  localparam int EMIT_W   = $clog2(EMIT_MAX + 1);
  localparam int CMP_W    = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_LEN    = 3'd0,
    REG_KEY_LOW    = 3'd1,
    REG_KEY_HIGH   = 3'd2,
    REG_REPL_LEN   = 3'd3,
    REG_REPL_LOW   = 3'd4,
    REG_REPL_HIGH  = 3'd5,
    REG_OUT_LIMIT  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [LEN_W-1:0]   key_len;
    logic [WORD_W-1:0]  key_low;
    logic [WORD_W-1:0]  key_high;
    logic [LEN_W-1:0]   repl_len;
    logic [WORD_W-1:0]  repl_low;
    logic [WORD_W-1:0]  repl_high;
    logic [LIMIT_W-1:0] out_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has_char;
    logic       fin_step;
    logic       fin;
  } tok_t;

endpackage

### rtl/stream_find_replace_top.sv
// Streaming find-and-replace over a byte stream.
// Input channel: in_valid_i/in_stall_o carry one text byte per transfer, with
// in_last_i marking the final byte of a string. Output channel:
// out_valid_o/out_stall_i carry one result item per transfer; has_byte_o is
// low only on a bare end marker, and out_last_o with truncated_o closes each
// string.
// The configuration port writes register cfg_index_i from cfg_data_i at any
// edge with cfg_we_i high; write only while no string work is pending.
// The front end takes one byte, updates the match window in that cycle and
// then pushes one queue entry per produced character, one per cycle while
// the queue is not full; a byte produces 0 to 16 entries (the window pops,
// the replacement text and the final flush) and holds the input side until
// the last is pushed. A byte that produces nothing does not stall the input.
// The first result of a byte passes the front-end registers, a queue entry
// and the output register. A four-entry queue and an output register let the
// front end keep working while the receiver stalls; while the queue is full
// the front end waits and in_stall_o stays high.
// Reset empties the window, clears the counters, empties the queue and the
// output register, and returns every configuration register to its reset value.
module stream_find_replace_top import sfr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [WORD_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           in_byte_i,
  input  logic                 in_last_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           out_byte_o,
  output logic                 has_byte_o,
  output logic                 out_last_o,
  output logic                 truncated_o
);

  cfg_t cfg_q;
  logic push;
  tok_t push_tok;
  logic q_full;
  logic q_valid;
  tok_t q_tok;
  logic q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_len   <= '0;
      cfg_q.key_low   <= '0;
      cfg_q.key_high  <= '0;
      cfg_q.repl_len  <= '0;
      cfg_q.repl_low  <= '0;
      cfg_q.repl_high <= '0;
      cfg_q.out_limit <= {LIMIT_W{1'b1}};
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_KEY_LEN:   cfg_q.key_len   <= cfg_data_i[LEN_W-1:0];
        REG_KEY_LOW:   cfg_q.key_low   <= cfg_data_i;
        REG_KEY_HIGH:  cfg_q.key_high  <= cfg_data_i;
        REG_REPL_LEN:  cfg_q.repl_len  <= cfg_data_i[LEN_W-1:0];
        REG_REPL_LOW:  cfg_q.repl_low  <= cfg_data_i;
        REG_REPL_HIGH: cfg_q.repl_high <= cfg_data_i;
        REG_OUT_LIMIT: cfg_q.out_limit <= cfg_data_i[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sfr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .push_o     (push),
    .tok_o      (push_tok),
    .q_full_i   (q_full)
  );

  sfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .tok_i   (push_tok),
    .full_o  (q_full),
    .valid_o (q_valid),
    .tok_o   (q_tok),
    .pop_i   (q_pop)
  );

  sfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .out_limit_i (cfg_q.out_limit),
    .tok_valid_i (q_valid),
    .tok_i       (q_tok),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .has_byte_o  (has_byte_o),
    .out_last_o  (out_last_o),
    .truncated_o (truncated_o)
  );

endmodule

### rtl/sfr_front.sv
module sfr_front import sfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       push_o,
  output tok_t       tok_o,
  input  logic       q_full_i
);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_EMIT = 2'b10
  } fstate_e;

  fstate_e                 state_q, state_d;
  logic [7:0]              win_q [KEY_MAX];
  logic [7:0]              win_d [KEY_MAX];
  logic [7:0]              win_ins [KEY_MAX];
  logic [FILL_W-1:0]       fill_q, fill_d;
  logic [EMIT_W-1:0]       rem_q, rem_d;
  logic [REPL_MAX*8-1:0]   repl_q, repl_d;
  logic                    is_repl_q, is_repl_d;
  logic                    bare_q, bare_d;
  logic                    fin_step_q, fin_step_d;

  logic [2*WORD_W-1:0]     key_bits;
  logic [2*WORD_W-1:0]     repl_bits;
  logic [FILL_W-1:0]       k_eff;
  logic [EMIT_W-1:0]       r_eff;
  logic [FILL_W-1:0]       f1;
  logic [EMIT_W-1:0]       n_emit;
  logic                    hit;

  assign key_bits  = {cfg_i.key_high, cfg_i.key_low};
  assign repl_bits = {cfg_i.repl_high, cfg_i.repl_low};
  assign k_eff = (cfg_i.key_len > LEN_W'(KEY_MAX)) ? FILL_W'(KEY_MAX)
                                                   : cfg_i.key_len[FILL_W-1:0];
  assign r_eff = (cfg_i.repl_len > LEN_W'(REPL_MAX)) ? EMIT_W'(REPL_MAX)
                                                     : EMIT_W'(cfg_i.repl_len);
  assign f1 = fill_q + FILL_W'(1);

  assign in_stall_o = (state_q != F_IDLE);

  always_comb begin
    for (int i = 0; i < KEY_MAX; i++) begin
      win_ins[i] = (FILL_W'(i) == fill_q) ? in_byte_i : win_q[i];
    end
    hit = 1'b1;
    for (int i = 0; i < KEY_MAX; i++) begin
      if ((FILL_W'(i) < k_eff) && (win_ins[i] != key_bits[8*i +: 8])) begin
        hit = 1'b0;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    win_d      = win_q;
    fill_d     = fill_q;
    rem_d      = rem_q;
    repl_d     = repl_q;
    is_repl_d  = is_repl_q;
    bare_d     = bare_q;
    fin_step_d = fin_step_q;
    n_emit     = '0;
    push_o     = 1'b0;

    tok_o.data     = bare_q ? 8'd0 : (is_repl_q ? repl_q[7:0] : win_q[0]);
    tok_o.has_char = !bare_q;
    tok_o.fin_step = fin_step_q;
    tok_o.fin      = fin_step_q && (rem_q == EMIT_W'(1));

    case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          win_d      = win_ins;
          fill_d     = f1;
          fin_step_d = in_last_i;
          is_repl_d  = 1'b0;
          bare_d     = 1'b0;
          if (f1 > k_eff) begin
            if (in_last_i || (k_eff == '0)) begin
              n_emit = EMIT_W'(f1);
            end else begin
              n_emit = EMIT_W'(f1 - k_eff + FILL_W'(1));
            end
          end else if ((f1 == k_eff) && hit) begin
            is_repl_d = 1'b1;
            fill_d    = '0;
            repl_d    = repl_bits[REPL_MAX*8-1:0];
            n_emit    = r_eff;
            if (in_last_i && (r_eff == '0)) begin
              bare_d = 1'b1;
              n_emit = EMIT_W'(1);
            end
          end else if (f1 == k_eff) begin
            n_emit = in_last_i ? EMIT_W'(f1) : EMIT_W'(1);
          end else begin
            n_emit = in_last_i ? EMIT_W'(f1) : '0;
          end
          rem_d = n_emit;
          if (n_emit != '0) begin
            state_d = F_EMIT;
          end
        end
      end
      F_EMIT: begin
        if (!q_full_i) begin
          push_o = 1'b1;
          rem_d  = rem_q - EMIT_W'(1);
          if (is_repl_q) begin
            repl_d = repl_q >> 8;
          end else begin
            for (int i = 0; i < KEY_MAX - 1; i++) begin
              win_d[i] = win_q[i+1];
            end
            fill_d = fill_q - FILL_W'(1);
          end
          if (rem_q == EMIT_W'(1)) begin
            state_d = F_IDLE;
          end
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= F_IDLE;
      fill_q     <= '0;
      rem_q      <= '0;
      is_repl_q  <= 1'b0;
      bare_q     <= 1'b0;
      fin_step_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      rem_q      <= rem_d;
      is_repl_q  <= is_repl_d;
      bare_q     <= bare_d;
      fin_step_q <= fin_step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q  <= win_d;
    repl_q <= repl_d;
  end

`ifndef SYNTHESIS
  a_idle_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_IDLE) |-> (fill_q < FILL_W'(KEY_MAX)))
    else $error("window full while waiting for input");
  a_emit_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_EMIT) |-> (rem_q != '0))
    else $error("emitting with no transfers left");
`endif

endmodule

### rtl/sfr_queue.sv
module sfr_queue import sfr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  tok_t tok_i,
  output logic full_o,
  output logic valid_o,
  output tok_t tok_o,
  input  logic pop_i
);

  tok_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign tok_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + QPTR_W'(1) : wr_q;
    rd_d  = do_pop ? rd_q + QPTR_W'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= tok_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

### rtl/sfr_back.sv
module sfr_back import sfr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [LIMIT_W-1:0] out_limit_i,
  input  logic               tok_valid_i,
  input  tok_t               tok_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               has_byte_o,
  output logic               out_last_o,
  output logic               truncated_o
);

  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                  drop_q, drop_d;
  logic                  done_q, done_d;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            byte_q;
  logic                  has_q;
  logic                  last_q;
  logic                  trunc_q;

  logic [CMP_W-1:0]      lim_wide;
  logic [COUNT_BITS-1:0] lim;
  logic [COUNT_BITS:0]   cnt_inc;
  logic                  can_emit;
  logic                  at_lim_next;
  logic                  produce;
  logic                  out_free;
  logic [7:0]            o_byte;
  logic                  o_has;
  logic                  o_last;
  logic                  o_trunc;

  assign lim_wide = (CMP_W'(out_limit_i) > CMP_W'({COUNT_BITS{1'b1}}))
                    ? CMP_W'({COUNT_BITS{1'b1}}) : CMP_W'(out_limit_i);
  assign lim         = lim_wide[COUNT_BITS-1:0];
  assign cnt_inc     = {1'b0, cnt_q} + (COUNT_BITS+1)'(1);
  assign can_emit    = (cnt_q < lim);
  assign at_lim_next = !(cnt_inc < {1'b0, lim});
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    produce = 1'b0;
    o_byte  = 8'd0;
    o_has   = 1'b0;
    o_last  = 1'b0;
    o_trunc = 1'b0;
    cnt_d   = cnt_q;
    drop_d  = drop_q;
    done_d  = done_q;

    if (done_q) begin
      produce = 1'b0;
    end else if (tok_i.has_char && can_emit) begin
      produce = 1'b1;
      o_byte  = tok_i.data;
      o_has   = 1'b1;
      o_last  = tok_i.fin || (tok_i.fin_step && at_lim_next);
      o_trunc = o_last && (drop_q || !tok_i.fin);
      cnt_d   = cnt_inc[COUNT_BITS-1:0];
      done_d  = o_last && !tok_i.fin;
    end else if (tok_i.has_char) begin
      drop_d = 1'b1;
      if (tok_i.fin) begin
        produce = 1'b1;
        o_last  = 1'b1;
        o_trunc = 1'b1;
      end
    end else begin
      produce = 1'b1;
      o_last  = 1'b1;
      o_trunc = drop_q;
    end

    if (tok_i.fin) begin
      cnt_d  = '0;
      drop_d = 1'b0;
      done_d = 1'b0;
    end

    pop_o = tok_valid_i && (!produce || out_free);

    if (pop_o && produce) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      drop_q      <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        cnt_q  <= cnt_d;
        drop_q <= drop_d;
        done_q <= done_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && produce) begin
      byte_q  <= o_byte;
      has_q   <= o_has;
      last_q  <= o_last;
      trunc_q <= o_trunc;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = byte_q;
  assign has_byte_o  = has_q;
  assign out_last_o  = last_q;
  assign truncated_o = trunc_q;

`ifndef SYNTHESIS
  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !has_q) |-> last_q)
    else $error("end marker without last flag");
  a_trunc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && trunc_q) |-> last_q)
    else $error("truncation flag on a non-final item");
  a_done_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (cnt_q != '0))
    else $error("string closed early with nothing emitted");
`endif

endmodule

### verif/tb_top.sv
module tb_top;
  import sfr_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int IDLE_LIMIT    = 3000;
  localparam int RANDOM_BYTES  = 200;
  localparam int MAX_PER_BYTE  = 16;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_ch;
    logic       fin;
    logic       trunc;
  } text_out_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } text_in_t;

  class text_scoreboard;
    cfg_t      regs;
    logic [7:0] window [KEY_MAX];
    int        fill;
    longint    emitted;
    bit        dropped;
    text_out_t expected_text[$];
    text_out_t step_out[$];
    int        mismatches;

    function new();
      regs = '0;
      regs.out_limit = '1;
      fill = 0;
      emitted = 0;
      dropped = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
      case (cfg_reg_e'(idx))
        REG_KEY_LEN:   regs.key_len = data[LEN_W-1:0];
        REG_KEY_LOW:   regs.key_low = data;
        REG_KEY_HIGH:  regs.key_high = data;
        REG_REPL_LEN:  regs.repl_len = data[LEN_W-1:0];
        REG_REPL_LOW:  regs.repl_low = data;
        REG_REPL_HIGH: regs.repl_high = data;
        REG_OUT_LIMIT: regs.out_limit = data[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function void emit_char(logic [7:0] ch);
      longint cap;
      longint lim;
      cap = (longint'(1) << COUNT_BITS) - 1;
      lim = (longint'(regs.out_limit) < cap) ? longint'(regs.out_limit) : cap;
      if (emitted < lim && step_out.size() < MAX_PER_BYTE) begin
        step_out.push_back(text_out_t'({ch, 1'b1, 1'b0, 1'b0}));
        emitted++;
      end else begin
        dropped = 1'b1;
      end
    endfunction

    function void release_oldest(int cnt);
      if (cnt > fill) cnt = fill;
      for (int i = 0; i < cnt; i++) emit_char(window[i]);
      for (int i = 0; i < fill - cnt; i++) window[i] = window[i + cnt];
      fill -= cnt;
    endfunction

    function void take_source_byte(logic [7:0] b, logic fin);
      int k;
      int r;
      bit hit;
      logic [127:0] key_bytes;
      logic [127:0] repl_bytes;
      text_out_t tail;
      key_bytes = {regs.key_high, regs.key_low};
      repl_bytes = {regs.repl_high, regs.repl_low};
      k = (regs.key_len > KEY_MAX) ? KEY_MAX : int'(regs.key_len);
      r = (regs.repl_len > REPL_MAX) ? REPL_MAX : int'(regs.repl_len);
      step_out.delete();
      if (fill < KEY_MAX) begin
        window[fill] = b;
        fill++;
      end
      // A window longer than the key comes from a key shortened mid-string or from a zero-length key.
      if (fill > k) begin
        release_oldest(k == 0 ? fill : fill - k + 1);
      end else if (fill == k) begin
        hit = 1'b1;
        for (int i = 0; i < k; i++) begin
          if (window[i] != key_bytes[8*i +: 8]) hit = 1'b0;
        end
        if (hit) begin
          for (int i = 0; i < r; i++) emit_char(repl_bytes[8*i +: 8]);
          fill = 0;
        end else begin
          release_oldest(1);
        end
      end
      if (fin) begin
        release_oldest(fill);
        if (step_out.size() == 0) step_out.push_back('0);
        tail = step_out.pop_back();
        tail.fin = 1'b1;
        tail.trunc = dropped;
        step_out.push_back(tail);
        fill = 0;
        emitted = 0;
        dropped = 1'b0;
      end
      foreach (step_out[i]) expected_text.push_back(step_out[i]);
    endfunction

    function void check_output(text_out_t got);
      text_out_t want;
      if (expected_text.size() == 0) begin
        mismatches++;
        $display("%0t: expected no output, got byte %h has %b last %b trunc %b",
                 $time, got.ch, got.has_ch, got.fin, got.trunc);
      end else begin
        want = expected_text.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: expected byte %h has %b last %b trunc %b,", $time,
                   want.ch, want.has_ch, want.fin, want.trunc,
                   " got byte %h has %b last %b trunc %b",
                   got.ch, got.has_ch, got.fin, got.trunc);
        end
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [WORD_W-1:0]    cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [7:0]           in_byte_i = '0;
  logic                 in_last_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [7:0]           out_byte_o;
  logic                 has_byte_o;
  logic                 out_last_o;
  logic                 truncated_o;

  text_scoreboard book;
  cfg_t           cur_cfg;
  text_in_t       text_q[$];
  int             random_bytes_sent = 0;
  int             idle_cycles = 0;
  int             stall_mode = 0;
  int             mode_left = 0;
  int             stall_tick = 0;

  stream_find_replace_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .has_byte_o  (has_byte_o),
    .out_last_o  (out_last_o),
    .truncated_o (truncated_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left <= $urandom_range(20, 150);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 3) != 0);
      3: out_stall_i <= ((stall_tick % 7) < 5);
      default: out_stall_i <= 1'b0;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) book.write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) book.take_source_byte(in_byte_i, in_last_i);
      if (out_valid_o && !out_stall_i) begin
        book.check_output(text_out_t'({out_byte_o, has_byte_o, out_last_o, truncated_o}));
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic put_reg(cfg_reg_e idx, logic [WORD_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  task automatic apply_config();
    put_reg(REG_KEY_LEN, WORD_W'(cur_cfg.key_len));
    put_reg(REG_KEY_LOW, cur_cfg.key_low);
    put_reg(REG_KEY_HIGH, cur_cfg.key_high);
    put_reg(REG_REPL_LEN, WORD_W'(cur_cfg.repl_len));
    put_reg(REG_REPL_LOW, cur_cfg.repl_low);
    put_reg(REG_REPL_HIGH, cur_cfg.repl_high);
    put_reg(REG_OUT_LIMIT, WORD_W'(cur_cfg.out_limit));
    cfg_we_i <= 1'b0;
  endtask

  task automatic settle();
    while (book.expected_text.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic add_byte(logic [7:0] ch, logic fin);
    text_q.push_back(text_in_t'({ch, fin}));
  endtask

  task automatic drive_text(bit is_random);
    text_in_t item;
    int burst;
    int gap;
    burst = $urandom_range(1, 24);
    while (text_q.size() != 0) begin
      item = text_q.pop_front();
      in_valid_i <= 1'b1;
      in_byte_i <= item.ch;
      in_last_i <= item.fin;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      if (is_random) random_bytes_sent++;
      burst--;
      if (burst == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst = $urandom_range(1, 40);
      end
    end
    in_valid_i <= 1'b0;
  endtask

  // Most text is built from pieces of the key so that matches and near misses are common.
  task automatic push_text(int n, bit close);
    int k;
    int left;
    int plen;
    int sel;
    int idx;
    logic [127:0] kb;
    text_in_t tail;
    k = (cur_cfg.key_len > KEY_MAX) ? KEY_MAX : int'(cur_cfg.key_len);
    kb = {cur_cfg.key_high, cur_cfg.key_low};
    left = n;
    while (left > 0) begin
      sel = $urandom_range(0, 9);
      if (k > 0 && sel < 5) begin
        plen = ($urandom_range(0, 2) == 0) ? $urandom_range(1, k) : k;
        if (plen > left) plen = left;
        for (int i = 0; i < plen; i++) add_byte(kb[8*i +: 8], 1'b0);
        left -= plen;
      end else if (k > 0 && sel < 7) begin
        idx = $urandom_range(0, k - 1);
        add_byte(kb[8*idx +: 8], 1'b0);
        left--;
      end else begin
        add_byte(8'($urandom), 1'b0);
        left--;
      end
    end
    if (close) begin
      tail = text_q.pop_back();
      tail.fin = 1'b1;
      text_q.push_back(tail);
    end
  endtask

  task automatic pick_config();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: cur_cfg.key_len = '0;
      1: cur_cfg.key_len = LEN_W'(KEY_MAX);
      2: cur_cfg.key_len = LEN_W'($urandom_range(KEY_MAX + 1, 31));
      default: cur_cfg.key_len = LEN_W'($urandom_range(1, 5));
    endcase
    cur_cfg.key_low = {$urandom, $urandom};
    cur_cfg.key_high = {$urandom, $urandom};
    sel = $urandom_range(0, 9);
    case (sel)
      0: cur_cfg.repl_len = '0;
      1: cur_cfg.repl_len = LEN_W'(REPL_MAX);
      2: cur_cfg.repl_len = LEN_W'($urandom_range(REPL_MAX + 1, 31));
      default: cur_cfg.repl_len = LEN_W'($urandom_range(0, 6));
    endcase
    cur_cfg.repl_low = {$urandom, $urandom};
    cur_cfg.repl_high = {$urandom, $urandom};
    if ($urandom_range(0, 5) == 0) begin
      cur_cfg.repl_len = cur_cfg.key_len;
      cur_cfg.repl_low = cur_cfg.key_low;
      cur_cfg.repl_high = cur_cfg.key_high;
    end
    sel = $urandom_range(0, 7);
    case (sel)
      0: cur_cfg.out_limit = '0;
      1: cur_cfg.out_limit = LIMIT_W'($urandom_range(1, 12));
      2: cur_cfg.out_limit = LIMIT_W'($urandom);
      default: cur_cfg.out_limit = '1;
    endcase
  endtask

  initial begin
    int strings;
    book = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Pass-through with a zero output limit: everything is dropped.
    cur_cfg = '0;
    apply_config();
    add_byte(8'h00, 1'b0);
    add_byte(8'hff, 1'b1);
    drive_text(1'b0);
    settle();

    // Key "ab" becomes "XYZ" after a near miss, and the last byte is plain text.
    cur_cfg.key_len = LEN_W'(2);
    cur_cfg.key_low = 64'h6261;
    cur_cfg.repl_len = LEN_W'(3);
    cur_cfg.repl_low = 64'h5a5958;
    cur_cfg.out_limit = '1;
    apply_config();
    add_byte(8'h61, 1'b0);
    add_byte(8'h61, 1'b0);
    add_byte(8'h62, 1'b0);
    add_byte(8'h63, 1'b1);
    drive_text(1'b0);
    settle();

    // An empty replacement deletes the match and leaves a bare end marker.
    cur_cfg.repl_len = '0;
    apply_config();
    add_byte(8'h61, 1'b0);
    add_byte(8'h62, 1'b1);
    drive_text(1'b0);
    settle();

    // Oversized lengths saturate, and a replacement equal to the key passes text through.
    cur_cfg.key_len = '1;
    cur_cfg.key_low = {$urandom, $urandom};
    cur_cfg.key_high = {$urandom, $urandom};
    cur_cfg.repl_len = '1;
    cur_cfg.repl_low = cur_cfg.key_low;
    cur_cfg.repl_high = cur_cfg.key_high;
    apply_config();
    for (int i = 0; i < KEY_MAX; i++) begin
      add_byte(i < 8 ? cur_cfg.key_low[8*i +: 8] : cur_cfg.key_high[8*(i-8) +: 8],
               i == KEY_MAX - 1);
    end
    drive_text(1'b0);
    settle();

    // The key is shortened while three bytes wait in the window.
    cur_cfg.key_len = LEN_W'(4);
    cur_cfg.key_low = 64'h64636261;
    cur_cfg.key_high = '0;
    cur_cfg.repl_len = LEN_W'(3);
    cur_cfg.repl_low = 64'h5a5958;
    apply_config();
    add_byte(8'h61, 1'b0);
    add_byte(8'h62, 1'b0);
    add_byte(8'h63, 1'b0);
    drive_text(1'b0);
    settle();
    cur_cfg.key_len = LEN_W'(1);
    apply_config();
    add_byte(8'h78, 1'b1);
    drive_text(1'b0);
    settle();

    while (random_bytes_sent < RANDOM_BYTES) begin
      pick_config();
      apply_config();
      strings = $urandom_range(1, 4);
      for (int s = 0; s < strings; s++) begin
        push_text($urandom_range(1, 24), (s != strings - 1) || ($urandom_range(0, 4) != 0));
      end
      drive_text(1'b1);
      settle();
    end

    if (book.mismatches == 0 && book.expected_text.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
